// ===== rtl/particle_wall_interaction_defines.svh =====
// Assertion macros shared by the checker files of the particle wall block.
// Depends on nothing; every macro expects signals named clock and reset in scope.
`ifndef PARTICLE_WALL_INTERACTION_DEFINES_SVH
`define PARTICLE_WALL_INTERACTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PWI_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("particle wall check failed");

// Next-cycle implication, disabled while reset is high.
`define PWI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("particle wall check failed");

`endif

// ===== rtl/pwi_pkg.sv =====
// Shared types, codes and fixed-point helpers of the particle wall block.
// Used by pwi_table and particle_wall_interaction; depends on nothing.
package pwi_pkg;

   // Word actions.
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_IMPACT = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   // Patch interaction kinds.
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_ESCAPE  = 2'd1;
   localparam logic [1:0] KIND_STICK   = 2'd2;
   localparam logic [1:0] KIND_REBOUND = 2'd3;

   localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;
   localparam logic [47:0] MASS_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [31:0] E_RESET = 32'sd65536;

   // Per-patch totals.
   typedef struct packed {
      logic [31:0] esc_cnt;
      logic [47:0] esc_mass;
      logic [31:0] stk_cnt;
      logic [47:0] stk_mass;
   } totals_type;

   // Command from the sequencer to the patch table.
   typedef struct packed {
      logic              update;
      logic [1:0]        action;
      logic [3:0]        patch;
      logic [1:0]        kind;
      logic signed [31:0] e;
      logic signed [31:0] mu;
      logic [31:0]       mass;
   } tbl_cmd_type;

   // Round x / 2^s to nearest, ties away from zero.
   function automatic logic signed [67:0] rnd(input logic signed [67:0] x,
                                               input logic [4:0] s);
      logic signed [67:0] half;
      logic signed [67:0] bias;
      half = 68'sd1 <<< (s - 5'd1);
      bias = x[67] ? (half - 68'sd1) : half;
      return (x + bias) >>> s;
   endfunction

   // Saturate to signed 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
      logic signed [31:0] r;
      if (x > 68'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -68'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/particle_wall_interaction.sv =====
// Particle wall interaction: a load, read or impact word is accepted when idle and
// gives one result word; a rebound impact is worked by one shared 35x33 multiplier
// stepped through 18 steps, the H and L steps skipped when the normal speed is not
// positive. busy is high while a word is worked on and low again when its result
// strobe is shown, so a new word is taken only once the last is through; the receiver cannot stall.
// Synchronous reset clears the sequencer and loads every patch with kind none,
// restitution 1.0, friction 0, totals 0.
module particle_wall_interaction #(
   parameter int PATCHES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_patch,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic signed [15:0] req_norm_x,
   input  logic signed [15:0] req_norm_y,
   input  logic signed [15:0] req_norm_z,
   input  logic signed [31:0] req_wall_x,
   input  logic signed [31:0] req_wall_y,
   input  logic signed [31:0] req_wall_z,
   input  logic [31:0]        req_parcel_mass,
   output logic               rsp_valid,
   output logic               rsp_handled,
   output logic               rsp_keep,
   output logic               rsp_moving,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [31:0]        rsp_escape_count,
   output logic [47:0]        rsp_escape_mass,
   output logic [31:0]        rsp_stick_count,
   output logic [47:0]        rsp_stick_mass
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_EXEC    = 2'd1;
   localparam logic [1:0] S_ISSUE   = 2'd2;
   localparam logic [1:0] S_CONSUME = 2'd3;

   // Rebound steps.
   localparam logic [4:0] ST_D0  = 5'd0;
   localparam logic [4:0] ST_D1  = 5'd1;
   localparam logic [4:0] ST_D2  = 5'd2;
   localparam logic [4:0] ST_UN  = 5'd3;
   localparam logic [4:0] ST_UT0 = 5'd4;
   localparam logic [4:0] ST_UT1 = 5'd5;
   localparam logic [4:0] ST_UT2 = 5'd6;
   localparam logic [4:0] ST_K   = 5'd7;
   localparam logic [4:0] ST_H0  = 5'd8;
   localparam logic [4:0] ST_L0  = 5'd9;
   localparam logic [4:0] ST_H1  = 5'd10;
   localparam logic [4:0] ST_L1  = 5'd11;
   localparam logic [4:0] ST_H2  = 5'd12;
   localparam logic [4:0] ST_L2  = 5'd13;
   localparam logic [4:0] ST_F0  = 5'd14;
   localparam logic [4:0] ST_F1  = 5'd15;
   localparam logic [4:0] ST_F2  = 5'd16;
   localparam logic [4:0] ST_OUT = 5'd17;

   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;

   // Latched word.
   logic [1:0]         act_ff;
   logic [3:0]         patch_ff;
   logic signed [31:0] v_ff [3];
   logic signed [32:0] r_ff [3];
   logic signed [15:0] n_ff [3];
   logic [31:0]        mass_ff;

   // Rebound working registers.
   logic signed [33:0] e1_ff;
   logic signed [31:0] mu_ff;
   logic signed [67:0] acc_ff;
   logic signed [31:0] un_ff;
   logic               pos_ff;
   logic signed [31:0] ut_ff [3];
   logic signed [49:0] k_ff;
   logic signed [51:0] dn_ff [3];
   logic signed [49:0] f_ff  [3];

   // Result registers.
   logic               rsp_valid_ff;
   logic               handled_ff, keep_ff, moving_ff;
   logic signed [31:0] out_ff [3];
   pwi_pkg::totals_type tot_ff;

   // Results of the execute cycle.
   logic                exec_handled, exec_keep, exec_moving;
   logic signed [31:0]  exec_out [3];
   pwi_pkg::totals_type exec_tot;

   logic               accept;
   logic               patch_ok;
   logic [1:0]         axis;
   logic signed [34:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [67:0] prod;

   pwi_pkg::tbl_cmd_type cmd;
   logic [1:0]           tbl_kind;
   logic signed [31:0]   tbl_e, tbl_mu;
   pwi_pkg::totals_type  tot_before, tot_after;
   logic [1:0]           kind_eff;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign patch_ok = (32'(patch_ff) < PATCHES);
   assign kind_eff = patch_ok ? tbl_kind : pwi_pkg::KIND_NONE;

   // Table command, issued once in the execute cycle.
   always_comb begin
      cmd.update = (state_ff == S_EXEC) && patch_ok;
      cmd.action = act_ff;
      cmd.patch  = patch_ff;
      cmd.kind   = (act_ff == pwi_pkg::ACT_LOAD) ? v_ff[0][1:0] : tbl_kind;
      cmd.e      = v_ff[1];
      cmd.mu     = v_ff[2];
      cmd.mass   = mass_ff;
   end

   pwi_table #(.PATCHES(PATCHES)) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .kind  (tbl_kind),
      .e     (tbl_e),
      .mu    (tbl_mu),
      .held  (tot_before),
      .after (tot_after)
   );

   pwi_mul u_mul (
      .clock(clock),
      .mul_a(mul_a),
      .mul_b(mul_b),
      .prod (prod)
   );

   // Axis handled by the current step.
   always_comb begin
      case (step_ff)
         ST_D0, ST_UT0, ST_H0, ST_L0, ST_F0: axis = 2'd0;
         ST_D1, ST_UT1, ST_H1, ST_L1, ST_F1: axis = 2'd1;
         ST_D2, ST_UT2, ST_H2, ST_L2, ST_F2: axis = 2'd2;
         default:                            axis = 2'd0;
      endcase
   end

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         ST_D0, ST_D1, ST_D2: begin
            mul_a = {{2{r_ff[axis][32]}}, r_ff[axis]};
            mul_b = {{17{n_ff[axis][15]}}, n_ff[axis]};
         end
         ST_UT0, ST_UT1, ST_UT2: begin
            mul_a = {{3{un_ff[31]}}, un_ff};
            mul_b = {{17{n_ff[axis][15]}}, n_ff[axis]};
         end
         ST_K: begin
            mul_a = {e1_ff[33], e1_ff};
            mul_b = {un_ff[31], un_ff};
         end
         ST_H0, ST_H1, ST_H2: begin
            mul_a = {{10{k_ff[49]}}, k_ff[49:25]};
            mul_b = {{17{n_ff[axis][15]}}, n_ff[axis]};
         end
         ST_L0, ST_L1, ST_L2: begin
            mul_a = {10'b0, k_ff[24:0]};
            mul_b = {{17{n_ff[axis][15]}}, n_ff[axis]};
         end
         ST_F0, ST_F1, ST_F2: begin
            mul_a = {{3{mu_ff[31]}}, mu_ff};
            mul_b = {ut_ff[axis][31], ut_ff[axis]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            step_in = ST_D0;
            if ((act_ff == pwi_pkg::ACT_IMPACT) && (kind_eff == pwi_pkg::KIND_REBOUND)) begin
               state_in = S_ISSUE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ISSUE: begin
            state_in = S_CONSUME;
         end
         S_CONSUME: begin
            if (step_ff == ST_OUT) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_ISSUE;
               if ((step_ff == ST_K) && !pos_ff) begin
                  step_in = ST_F0;
               end else begin
                  step_in = step_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_D0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= ((state_ff == S_EXEC) && (state_in == S_IDLE)) ||
                         ((state_ff == S_CONSUME) && (step_ff == ST_OUT));
      end
   end

   // Capture the word and the wall-relative velocity.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_action;
         patch_ff <= req_patch;
         mass_ff  <= req_parcel_mass;
         v_ff[0]  <= req_vel_x;
         v_ff[1]  <= req_vel_y;
         v_ff[2]  <= req_vel_z;
         n_ff[0]  <= req_norm_x;
         n_ff[1]  <= req_norm_y;
         n_ff[2]  <= req_norm_z;
         r_ff[0]  <= {req_vel_x[31], req_vel_x} - {req_wall_x[31], req_wall_x};
         r_ff[1]  <= {req_vel_y[31], req_vel_y} - {req_wall_y[31], req_wall_y};
         r_ff[2]  <= {req_vel_z[31], req_vel_z} - {req_wall_z[31], req_wall_z};
      end
   end

   // Result fields of load, read, no-op and non-rebound impact words.
   always_comb begin
      exec_handled = 1'b0;
      exec_keep    = 1'b0;
      exec_moving  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         exec_out[i] = '0;
      end
      exec_tot = '0;
      case (act_ff)
         pwi_pkg::ACT_LOAD: begin
            if (patch_ok) exec_tot = tot_before;
         end
         pwi_pkg::ACT_READ: begin
            if (patch_ok) exec_tot = tot_before;
         end
         pwi_pkg::ACT_IMPACT: begin
            if (patch_ok) exec_tot = tot_after;
            case (kind_eff)
               pwi_pkg::KIND_NONE: begin
                  exec_keep   = 1'b1;
                  exec_moving = 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     exec_out[i] = v_ff[i];
                  end
               end
               pwi_pkg::KIND_ESCAPE: begin
                  exec_handled = 1'b1;
               end
               pwi_pkg::KIND_STICK: begin
                  exec_handled = 1'b1;
                  exec_keep    = 1'b1;
               end
               default: begin
                  exec_handled = 1'b0;
               end
            endcase
         end
         default: begin
            exec_tot = '0;
         end
      endcase
   end

   // Execute cycle results and rebound steps.
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         e1_ff <= {{2{tbl_e[31]}}, tbl_e} + 34'sd65536;
         mu_ff <= tbl_mu;
         for (int i = 0; i < 3; i++) begin
            dn_ff[i] <= '0;
         end
         handled_ff <= exec_handled;
         keep_ff    <= exec_keep;
         moving_ff  <= exec_moving;
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= exec_out[i];
         end
         tot_ff <= exec_tot;
      end else if (state_ff == S_CONSUME) begin
         case (step_ff)
            ST_D0: acc_ff <= prod;
            ST_D1, ST_D2: acc_ff <= acc_ff + prod;
            ST_UN: begin
               un_ff  <= pwi_pkg::sat32(pwi_pkg::rnd(acc_ff, 5'd14));
               pos_ff <= (acc_ff > 68'sd0);
            end
            ST_UT0, ST_UT1, ST_UT2: begin
               ut_ff[axis] <= pwi_pkg::sat32($signed({{35{r_ff[axis][32]}}, r_ff[axis]}) -
                                             pwi_pkg::rnd(prod, 5'd14));
            end
            ST_K: k_ff <= 50'(pwi_pkg::rnd(prod, 5'd16));
            ST_H0, ST_H1, ST_H2: acc_ff <= prod <<< 25;
            ST_L0, ST_L1, ST_L2: dn_ff[axis] <= 52'(pwi_pkg::rnd(acc_ff + prod, 5'd14));
            ST_F0, ST_F1, ST_F2: f_ff[axis] <= 50'(pwi_pkg::rnd(prod, 5'd16));
            ST_OUT: begin
               handled_ff <= 1'b1;
               keep_ff    <= 1'b1;
               moving_ff  <= 1'b1;
               for (int i = 0; i < 3; i++) begin
                  out_ff[i] <= pwi_pkg::sat32($signed({{36{v_ff[i][31]}}, v_ff[i]}) -
                                              $signed({{16{dn_ff[i][51]}}, dn_ff[i]}) -
                                              $signed({{18{f_ff[i][49]}}, f_ff[i]}));
               end
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_handled      = handled_ff;
   assign rsp_keep         = keep_ff;
   assign rsp_moving       = moving_ff;
   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_escape_count = tot_ff.esc_cnt;
   assign rsp_escape_mass  = tot_ff.esc_mass;
   assign rsp_stick_count  = tot_ff.stk_cnt;
   assign rsp_stick_mass   = tot_ff.stk_mass;

endmodule

// ===== rtl/pwi_mul.sv =====
// Shared signed multiplier of the rebound datapath, product registered.
// Depends on nothing.
module pwi_mul (
   input  logic               clock,
   input  logic signed [34:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [67:0] prod
);

   logic signed [67:0] prod_ff;

   // One product per cycle.
   always_ff @(posedge clock) begin
      prod_ff <= 68'(mul_a) * 68'(mul_b);
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/pwi_table.sv =====
// Per-patch interaction table and escape/stick totals.
// Depends on pwi_pkg.
module pwi_table #(
   parameter int PATCHES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  pwi_pkg::tbl_cmd_type cmd,
   output logic [1:0]          kind,
   output logic signed [31:0]  e,
   output logic signed [31:0]  mu,
   output pwi_pkg::totals_type held,
   output pwi_pkg::totals_type after
);

   // Only sixteen patches are addressable by the patch field.
   localparam int DEPTH = (PATCHES < 16) ? PATCHES : 16;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [1:0]          kind_ff [DEPTH];
   logic signed [31:0]  e_ff    [DEPTH];
   logic signed [31:0]  mu_ff   [DEPTH];
   pwi_pkg::totals_type tot_ff  [DEPTH];

   logic [IW-1:0] idx;
   logic [48:0]   mass_sum;
   logic [47:0]   mass_sat;
   logic [47:0]   mass_sel;

   assign idx  = cmd.patch[IW-1:0];
   assign kind = kind_ff[idx];
   assign e    = e_ff[idx];
   assign mu   = mu_ff[idx];
   assign held = tot_ff[idx];

   // Saturating update of the totals for this word; a read word clears them.
   assign mass_sel = (cmd.kind == pwi_pkg::KIND_ESCAPE) ? held.esc_mass : held.stk_mass;
   assign mass_sum = {1'b0, mass_sel} + {17'b0, cmd.mass};
   assign mass_sat = mass_sum[48] ? pwi_pkg::MASS_MAX : mass_sum[47:0];

   always_comb begin
      after = held;
      case (cmd.action)
         pwi_pkg::ACT_READ: begin
            after = '0;
         end
         pwi_pkg::ACT_IMPACT: begin
            if (cmd.kind == pwi_pkg::KIND_ESCAPE) begin
               if (held.esc_cnt != pwi_pkg::CNT_MAX) after.esc_cnt = held.esc_cnt + 32'd1;
               after.esc_mass = mass_sat;
            end else if (cmd.kind == pwi_pkg::KIND_STICK) begin
               if (held.stk_cnt != pwi_pkg::CNT_MAX) after.stk_cnt = held.stk_cnt + 32'd1;
               after.stk_mass = mass_sat;
            end
         end
         default: begin
            after = held;
         end
      endcase
   end

   // Table storage; load words write the coefficients, all words to an existing patch write the totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            kind_ff[i] <= pwi_pkg::KIND_NONE;
            e_ff[i]    <= pwi_pkg::E_RESET;
            mu_ff[i]   <= '0;
            tot_ff[i]  <= '0;
         end
      end else if (cmd.update) begin
         if (cmd.action == pwi_pkg::ACT_LOAD) begin
            kind_ff[idx] <= cmd.kind;
            e_ff[idx]    <= cmd.e;
            mu_ff[idx]   <= cmd.mu;
         end
         tot_ff[idx] <= after;
      end
   end

endmodule

// ===== rtl/pwi_checker.sv =====
// Port-level checks of the particle wall block, bound to its top level.
// Depends on particle_wall_interaction_defines.svh and particle_wall_interaction.
`include "particle_wall_interaction_defines.svh"

module pwi_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_keep,
   input logic rsp_moving
);

   // A result strobe lasts one cycle.
   `PWI_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid)
   // An accepted word makes the block busy.
   `PWI_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // The block is free again when its result is shown.
   `PWI_ASSERT_IMPL(a_rsp_free, rsp_valid, !busy)
   // A moving parcel is always kept.
   `PWI_ASSERT_IMPL(a_moving_keep, rsp_valid && rsp_moving, rsp_keep)

endmodule

bind particle_wall_interaction pwi_checker u_pwi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_keep  (rsp_keep),
   .rsp_moving(rsp_moving)
);
